### sv/qwt_pkg.sv
// Shared constants, codes and result type for the quoted word tokenizer.
package qwt_pkg;

  localparam int MAX_WORDS_DEF  = 63;
  localparam int WORD_BYTES_DEF = 253;
  localparam int QUEUE_DEPTH    = 4;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LOW_X  = 8'h78;
  localparam logic [7:0] CH_LOW_U  = 8'h75;
  localparam logic [7:0] CH_UP_U   = 8'h55;

  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_PLAIN  = 2'd1;
  localparam logic [1:0] MODE_QUOTED = 2'd2;

  localparam logic [3:0] ESC_NONE   = 4'd0;
  localparam logic [3:0] ESC_HEX2   = 4'd2;
  localparam logic [3:0] ESC_HEX4   = 4'd4;
  localparam logic [3:0] ESC_HEX8   = 4'd8;
  localparam logic [3:0] ESC_SELECT = 4'd15;

  localparam logic [1:0] KIND_BYTE     = 2'd0;
  localparam logic [1:0] KIND_WORD_END = 2'd1;
  localparam logic [1:0] KIND_LIST_END = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] char_out;
    logic       was_quoted;
    logic [5:0] word_index;
    logic       overflow;
  } qwt_res_t;

endpackage

### sv/qwt_scan.sv
// Scanner state and per-byte result generation for the quoted word tokenizer.
module qwt_scan #(
  parameter int MAX_WORDS  = qwt_pkg::MAX_WORDS_DEF,
  parameter int WORD_BYTES = qwt_pkg::WORD_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  logic [7:0]        char_in,
  output logic              res0_valid,
  output logic              res1_valid,
  output qwt_pkg::qwt_res_t res0,
  output qwt_pkg::qwt_res_t res1
);

  localparam int WS_W = $clog2(MAX_WORDS + 1);
  localparam int WL_W = $clog2(WORD_BYTES + 1);
  localparam logic [WS_W-1:0] MAX_W = WS_W'(MAX_WORDS);
  localparam logic [WL_W-1:0] MAX_L = WL_W'(WORD_BYTES);

  logic [1:0]      mode_r, mode_nxt;
  logic [3:0]      esc_r, esc_nxt;
  logic [WS_W-1:0] ws_r, ws_nxt;
  logic [WL_W-1:0] wl_r, wl_nxt;
  logic            drop_r, drop_nxt;

  logic            kept;
  logic [1:0]      mode;
  logic            do_byte;
  logic            do_end;
  logic            end_quoted;
  logic            list_end;
  logic [WS_W+5:0] ws_ext;
  logic [WS_W+5:0] ws_inc_ext;
  logic [5:0]      idx_now;
  logic [5:0]      idx_inc;

  assign kept       = ws_r < MAX_W;
  assign mode       = (mode_r == 2'd3) ? qwt_pkg::MODE_IDLE : mode_r;
  assign ws_ext     = {6'b0, ws_r};
  assign ws_inc_ext = {6'b0, ws_r} + (WS_W+6)'(1);
  assign idx_now    = ws_ext[5:0];
  assign idx_inc    = ws_inc_ext[5:0];

  always_comb begin
    mode_nxt   = mode_r;
    esc_nxt    = esc_r;
    ws_nxt     = ws_r;
    wl_nxt     = wl_r;
    drop_nxt   = drop_r;
    do_byte    = 1'b0;
    do_end     = 1'b0;
    end_quoted = 1'b0;
    list_end   = 1'b0;
    res0_valid = 1'b0;
    res1_valid = 1'b0;
    res0       = '0;
    res1       = '0;
    res0.overflow = drop_r;
    res1.overflow = drop_r;

    if (char_in == qwt_pkg::CH_NUL) begin
      list_end   = 1'b1;
      do_end     = (mode == qwt_pkg::MODE_PLAIN) || (mode == qwt_pkg::MODE_QUOTED);
      end_quoted = (mode == qwt_pkg::MODE_QUOTED);
    end else if (mode == qwt_pkg::MODE_IDLE) begin
      if (char_in > qwt_pkg::CH_SPACE) begin
        if (!kept) begin
          drop_nxt = 1'b1;
        end
        wl_nxt  = '0;
        esc_nxt = qwt_pkg::ESC_NONE;
        if (char_in == qwt_pkg::CH_QUOTE) begin
          mode_nxt = qwt_pkg::MODE_QUOTED;
        end else begin
          mode_nxt = qwt_pkg::MODE_PLAIN;
          do_byte  = 1'b1;
        end
      end
    end else if (mode == qwt_pkg::MODE_PLAIN) begin
      if (char_in <= qwt_pkg::CH_SPACE) begin
        do_end = 1'b1;
      end else begin
        do_byte = 1'b1;
      end
    end else begin
      if (esc_r == qwt_pkg::ESC_SELECT) begin
        do_byte = 1'b1;
        if (char_in == qwt_pkg::CH_LOW_X) begin
          esc_nxt = qwt_pkg::ESC_HEX2;
        end else if (char_in == qwt_pkg::CH_LOW_U) begin
          esc_nxt = qwt_pkg::ESC_HEX4;
        end else if (char_in == qwt_pkg::CH_UP_U) begin
          esc_nxt = qwt_pkg::ESC_HEX8;
        end else begin
          esc_nxt = qwt_pkg::ESC_NONE;
        end
      end else if (esc_r != qwt_pkg::ESC_NONE) begin
        esc_nxt = esc_r - 4'd1;
        do_byte = 1'b1;
      end else if (char_in == qwt_pkg::CH_BSLASH) begin
        esc_nxt = qwt_pkg::ESC_SELECT;
        do_byte = 1'b1;
      end else if (char_in == qwt_pkg::CH_QUOTE) begin
        do_end     = 1'b1;
        end_quoted = 1'b1;
      end else begin
        do_byte = 1'b1;
      end
    end

    if (do_byte && kept) begin
      if (wl_r < MAX_L) begin
        res0_valid      = 1'b1;
        res0.kind       = qwt_pkg::KIND_BYTE;
        res0.char_out   = char_in;
        res0.word_index = idx_now;
        wl_nxt          = wl_r + WL_W'(1);
      end else begin
        drop_nxt = 1'b1;
      end
    end

    if (do_end) begin
      if (kept) begin
        res0_valid      = 1'b1;
        res0.kind       = qwt_pkg::KIND_WORD_END;
        res0.was_quoted = end_quoted;
        res0.word_index = idx_now;
        ws_nxt          = ws_r + WS_W'(1);
      end
      mode_nxt = qwt_pkg::MODE_IDLE;
      esc_nxt  = qwt_pkg::ESC_NONE;
      wl_nxt   = '0;
    end

    if (list_end) begin
      if (do_end && kept) begin
        res1_valid      = 1'b1;
        res1.kind       = qwt_pkg::KIND_LIST_END;
        res1.word_index = idx_inc;
      end else begin
        res0_valid      = 1'b1;
        res0.kind       = qwt_pkg::KIND_LIST_END;
        res0.word_index = idx_now;
      end
      mode_nxt = qwt_pkg::MODE_IDLE;
      esc_nxt  = qwt_pkg::ESC_NONE;
      ws_nxt   = '0;
      wl_nxt   = '0;
      drop_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= qwt_pkg::MODE_IDLE;
      esc_r  <= qwt_pkg::ESC_NONE;
      ws_r   <= '0;
      wl_r   <= '0;
      drop_r <= 1'b0;
    end else if (acc) begin
      mode_r <= mode_nxt;
      esc_r  <= esc_nxt;
      ws_r   <= ws_nxt;
      wl_r   <= wl_nxt;
      drop_r <= drop_nxt;
    end
  end

endmodule

### sv/qwt_outq.sv
// Result queue taking up to two results per cycle and releasing one.
module qwt_outq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push0,
  input  logic              push1,
  input  qwt_pkg::qwt_res_t din0,
  input  qwt_pkg::qwt_res_t din1,
  input  logic              pop,
  output logic              room2,
  output logic              not_empty,
  output qwt_pkg::qwt_res_t dout
);

  localparam int PW = $clog2(qwt_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(qwt_pkg::QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] ROOM_LIMIT = CW'(qwt_pkg::QUEUE_DEPTH - 2);

  qwt_pkg::qwt_res_t mem_r [qwt_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [PW-1:0] wp_plus1;
  logic [CW-1:0] n_push;

  assign wp_plus1  = wp_r + PW'(1);
  assign n_push    = CW'(push0) + CW'(push1);
  assign wp_nxt    = wp_r + n_push[PW-1:0];
  assign rp_nxt    = pop ? rp_r + PW'(1) : rp_r;
  assign cnt_nxt   = cnt_r + n_push - CW'(pop);
  assign room2     = cnt_r <= ROOM_LIMIT;
  assign not_empty = cnt_r != '0;
  assign dout      = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push0) begin
      mem_r[wp_r] <= din0;
    end
    if (push1) begin
      mem_r[wp_plus1] <= din1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### sv/quoted_word_tokenizer.sv
// Top level of the quoted word tokenizer: byte scanner feeding a result queue.
//
//   channel   direction  ports
//   in        input      in_valid, in_stall, in_char_in
//   out       output     out_valid, out_stall, out_kind, out_char_out,
//                        out_was_quoted, out_word_index, out_overflow
//
// One byte is taken per clock while in_stall is low; it yields zero, one or
// two results, which enter a four-entry queue in the same cycle. The
// end-of-string byte inside a kept word gives two results, so such bytes
// drain at one result per clock from the queue while out_stall is low.
// in_stall rises while the queue has fewer than two free entries.
// Synchronous active-low reset clears scanner state and the queue.
module quoted_word_tokenizer #(
  parameter int MAX_WORDS  = qwt_pkg::MAX_WORDS_DEF,
  parameter int WORD_BYTES = qwt_pkg::WORD_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_char_out,
  output logic       out_was_quoted,
  output logic [5:0] out_word_index,
  output logic       out_overflow
);

  logic              acc;
  logic              room2;
  logic              res0_valid;
  logic              res1_valid;
  qwt_pkg::qwt_res_t res0;
  qwt_pkg::qwt_res_t res1;
  qwt_pkg::qwt_res_t head;

  assign in_stall = !room2;
  assign acc      = in_valid && room2;

  qwt_scan #(
    .MAX_WORDS  (MAX_WORDS),
    .WORD_BYTES (WORD_BYTES)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .char_in    (in_char_in),
    .res0_valid (res0_valid),
    .res1_valid (res1_valid),
    .res0       (res0),
    .res1       (res1)
  );

  qwt_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push0     (acc && res0_valid),
    .push1     (acc && res1_valid),
    .din0      (res0),
    .din1      (res1),
    .pop       (out_valid && !out_stall),
    .room2     (room2),
    .not_empty (out_valid),
    .dout      (head)
  );

  assign out_kind       = head.kind;
  assign out_char_out   = head.char_out;
  assign out_was_quoted = head.was_quoted;
  assign out_word_index = head.word_index;
  assign out_overflow   = head.overflow;

endmodule
